// ===== design/psbc_pkg.sv =====
`timescale 1ns / 1ps
package psbc_pkg;
	localparam int unsigned EnterAngleDef = 13107;
	localparam int unsigned EnterRateDef = 131072;
	localparam int unsigned ExitAngleDef = 26214;
	localparam logic signed [33:0] TurnScale = 34'sd683565276;
	localparam logic signed [33:0] CosC2 = 34'sd80852;
	localparam logic signed [33:0] CosC4 = 34'sd16624;
	localparam logic signed [33:0] CosC6 = 34'sd1367;
	localparam logic signed [33:0] CosC8 = 34'sd60;
	localparam logic signed [33:0] OneQ16 = 34'sd65536;

	localparam logic [2:0] RegGainAngle = 3'd0;
	localparam logic [2:0] RegGainAngleRate = 3'd1;
	localparam logic [2:0] RegGainArm = 3'd2;
	localparam logic [2:0] RegGainArmRate = 3'd3;
	localparam logic [2:0] RegKin = 3'd4;
	localparam logic [2:0] RegPot = 3'd5;
	localparam logic [2:0] RegDamp = 3'd6;
	localparam logic [2:0] RegBalOnly = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
	} mul_op_t;

	function automatic logic signed [33:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 34'sd2147483647;
		end else if (v < -66'sd2147483648) begin
			return -34'sd2147483648;
		end
		return v[33:0];
	endfunction
endpackage

// ===== design/psbc_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module psbc_mul
	import psbc_pkg::*;
(
	input  logic               clk,
	input  mul_op_t            op,
	output logic signed [67:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= op.a * op.b;
	end
endmodule

// ===== design/pendulum_swingup_balance_controller.sv =====
`timescale 1ns / 1ps
// In balance and swing-up alike the sequencer walks 14 steps (0 to 13) of one shared
// 34x34 multiplier.
// The block takes no new input beat while it is still working on the last one.
// A waiting result holds off the next input beat until it is taken.
// Reset (arst_n low) clears the config registers, phase (swing-up) and the handshake, not the datapath.
module pendulum_swingup_balance_controller
	import psbc_pkg::*;
#(
	parameter int unsigned ENTER_ANGLE = EnterAngleDef,
	parameter int unsigned ENTER_RATE = EnterRateDef,
	parameter int unsigned EXIT_ANGLE = ExitAngleDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        valid,
	output logic        ready,
	input  logic [31:0] pend_angle,
	input  logic [31:0] pend_rate,
	input  logic [31:0] arm_angle,
	input  logic [31:0] arm_rate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] drive,
	output logic        in_balance
);
	logic [31:0] regs_q [7];
	logic bal_only_q, phase_q;
	state_t state_q, state_d;
	logic [3:0] step_q;
	logic signed [33:0] a_q, ad_q, m_q, md_q, c_q, acc1_q, sq_q, u_q;
	logic signed [65:0] sum_q;
	logic neg_q, zero_q;
	logic [31:0] ph_q;
	logic [31:0] ph_raw, ph_abs;
	mul_op_t op;
	logic signed [67:0] prod_q;
	logic signed [65:0] pf;
	logic [2:0] widx;
	logic [33:0] abs_a, abs_ad;
	logic phase_n;

	assign pready = 1'b1;
	assign widx = paddr[4:2];
	assign ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign pf = $signed(prod_q[65:0]) >>> 16;
	assign abs_a = (a_q < 0) ? -a_q : a_q;
	assign abs_ad = (ad_q < 0) ? -ad_q : ad_q;
	assign ph_raw = prod_q[47:16];
	assign ph_abs = ph_raw[31] ? 32'd0 - ph_raw : ph_raw;

	always_comb begin
		prdata = (widx == RegBalOnly) ? {31'd0, bal_only_q} : regs_q[widx];
	end

	psbc_mul u_mul (.clk(clk), .op(op), .prod_q(prod_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (valid) state_d = ST_RUN;
			ST_RUN:  if (step_q == 4'd13) state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Multiplier operand select per step. The product is registered and is read at the following step.
	// Steps that use pf feed the previous product straight back in.
	always_comb begin
		op.a = '0;
		op.b = '0;
		if (step_q == 4'd0) begin
			op.a = a_q;
			op.b = TurnScale;
		end else if (phase_q) begin
			case (step_q)
				4'd1: begin op.a = $signed({{2{regs_q[0][31]}}, regs_q[0]}); op.b = a_q; end
				4'd2: begin op.a = $signed({{2{regs_q[1][31]}}, regs_q[1]}); op.b = ad_q; end
				4'd3: begin op.a = $signed({{2{regs_q[2][31]}}, regs_q[2]}); op.b = m_q; end
				4'd4: begin op.a = $signed({{2{regs_q[3][31]}}, regs_q[3]}); op.b = md_q; end
				default: ;
			endcase
		end else begin
			case (step_q)
				4'd1: begin op.a = ad_q; op.b = ad_q; end
				4'd2: begin
					op.a = $signed({16'd0, ph_q[31:14]});
					op.b = $signed({16'd0, ph_q[31:14]});
				end
				4'd3: begin op.a = $signed({{2{regs_q[4][31]}}, regs_q[4]}); op.b = sq_q; end
				4'd4: begin op.a = CosC8; op.b = u_q; end
				4'd5: begin op.a = CosC6 - $signed(pf[33:0]); op.b = u_q; end
				4'd6: begin op.a = CosC4 - $signed(pf[33:0]); op.b = u_q; end
				4'd7: begin op.a = CosC2 - $signed(pf[33:0]); op.b = u_q; end
				4'd8: begin op.a = $signed({{2{regs_q[6][31]}}, regs_q[6]}); op.b = md_q; end
				4'd9: begin op.a = $signed({{2{regs_q[5][31]}}, regs_q[5]}); op.b = c_q - OneQ16; end
				4'd11: begin op.a = acc1_q; op.b = ad_q; end
				4'd12: begin op.a = sat32(pf); op.b = c_q; end
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n = phase_q;
		if (!phase_q) begin
			if (abs_a < 34'(ENTER_ANGLE) && abs_ad < 34'(ENTER_RATE)) phase_n = 1'b1;
		end else if (abs_a > 34'(EXIT_ANGLE)) begin
			phase_n = bal_only_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			bal_only_q <= 1'b0;
			phase_q <= 1'b0;
			for (int i = 0; i < 7; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				if (widx == RegBalOnly) begin
					bal_only_q <= pwdata[0];
					phase_q <= pwdata[0];
				end else begin
					regs_q[widx] <= pwdata;
				end
			end
			if (state_q == ST_IDLE && valid) step_q <= '0;
			else if (state_q == ST_RUN) step_q <= step_q + 4'd1;
			if (state_q == ST_RUN && step_q == 4'd0) phase_q <= phase_n;
		end
	end

	// Datapath; step 0 settles the phase, later steps consume products.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && valid) begin
			a_q <= $signed({{2{pend_angle[31]}}, pend_angle});
			ad_q <= $signed({{2{pend_rate[31]}}, pend_rate});
			m_q <= $signed({{2{arm_angle[31]}}, arm_angle});
			md_q <= $signed({{2{arm_rate[31]}}, arm_rate});
			sum_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (step_q == 4'd0) zero_q <= bal_only_q && phase_n && (abs_a > 34'(EXIT_ANGLE));
			if (phase_q) begin
				if (step_q >= 4'd2 && step_q <= 4'd5) sum_q <= sum_q + pf;
				if (step_q == 4'd6) acc1_q <= zero_q ? 34'sd0 : sat32(-sum_q);
			end else begin
				case (step_q)
					// Fold the turn phase to a quarter wave and remember the sign.
					4'd1: begin
						if (ph_abs >= 32'h4000_0000) begin
							neg_q <= 1'b1;
							ph_q <= 32'h8000_0000 - ph_abs;
						end else begin
							neg_q <= 1'b0;
							ph_q <= ph_abs;
						end
					end
					4'd2: sq_q <= sat32(pf);
					4'd3: u_q <= pf[33:0];
					4'd4: sq_q <= sat32(pf);
					4'd8: c_q <= neg_q ? pf[33:0] - OneQ16 : OneQ16 - pf[33:0];
					4'd9: sum_q <= pf;
					4'd10: acc1_q <= sat32(66'(sq_q) + 66'(sat32(pf)));
					4'd13: acc1_q <= sat32(66'(sat32(pf)) - sum_q);
					default: ;
				endcase
			end
		end
	end

	assign drive = acc1_q[31:0];
	assign in_balance = phase_q;
endmodule
